[rtl/core/zrlm_pkg.sv]
`default_nettype none

package zrlm_pkg;

    localparam int unsigned PIXEL_W     = 8;
    localparam int unsigned LABEL_W     = 8;
    localparam int unsigned COUNT_W     = 13;
    localparam int unsigned COUNT_MAX   = 8191;
    localparam int unsigned LABEL_MAX   = 255;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [COUNT_W-1:0] pend_count;
        logic               has_nz;
        logic               line_end;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/core/zero_run_length_map_core.sv]
// Zero run-length labeling of a pixel line with run-length coded results.
// Input channel: push, full, pixel, line_end. A transaction takes place at a
// rising edge with push high and full low; line_end marks the last pixel of a line.
// Result channel: empty, pop, run_label, repeat_count, line_last, item_last.
// The oldest result is shown while empty is low and leaves on an edge with pop high.
// A zero pixel extends the pending run and yields nothing unless it ends the line.
// A non-zero pixel yields the pending run, if any, then label 0 with count 1.
// Labels saturate at 255; run counts stop at min(MAX_LINE_WIDTH, 8191).
// A result passes through the command queue and then the result register.
// Throughput: one pixel per cycle while full is low; the result stage emits at
// most one result per cycle, so an item with two results holds the result stage
// for both of them while a four-entry command queue keeps taking pixels.
// Reset clears the run counter, the queue and the result valid flag and phase.
// When the receiver stalls, the result holds, the queue fills and full rises.
`default_nettype none

module zero_run_length_map_core #(
    parameter int unsigned MAX_LINE_WIDTH = 4096
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            push,
    output logic                           full,
    input  wire  [zrlm_pkg::PIXEL_W-1:0]   pixel,
    input  wire                            line_end,
    output logic                           empty,
    input  wire                            pop,
    output logic [zrlm_pkg::LABEL_W-1:0]   run_label,
    output logic [zrlm_pkg::COUNT_W-1:0]   repeat_count,
    output logic                           line_last,
    output logic                           item_last
);
    import zrlm_pkg::*;

    localparam int unsigned RunCap = (MAX_LINE_WIDTH < COUNT_MAX) ? MAX_LINE_WIDTH
                                                                  : COUNT_MAX;

    logic accept;
    logic cmd_wr;
    cmd_t cmd;
    cmd_t head;
    logic head_valid;
    logic head_pop;

    assign accept = push && !full;

    zrlm_front #(
        .RUN_CAP (RunCap)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel),
        .line_end (line_end),
        .accept   (accept),
        .cmd_wr   (cmd_wr),
        .cmd      (cmd)
    );

    zrlm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cmd_wr),
        .wr_data   (cmd),
        .rd_en     (head_pop),
        .rd_data   (head),
        .full      (full),
        .not_empty (head_valid)
    );

    zrlm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .head_pop     (head_pop),
        .pop          (pop),
        .empty        (empty),
        .run_label    (run_label),
        .repeat_count (repeat_count),
        .line_last    (line_last),
        .item_last    (item_last)
    );

endmodule

`default_nettype wire

[rtl/core/zrlm_front.sv]
`default_nettype none

module zrlm_front #(
    parameter int unsigned RUN_CAP = 4096
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire  [zrlm_pkg::PIXEL_W-1:0]   pixel,
    input  wire                            line_end,
    input  wire                            accept,
    output logic                           cmd_wr,
    output zrlm_pkg::cmd_t                 cmd
);
    import zrlm_pkg::*;

    localparam logic [COUNT_W-1:0] CapValue = COUNT_W'(RUN_CAP);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               is_zero;

    always_comb
    begin
        is_zero   = (pixel == '0);
        count_inc = (count_reg < CapValue) ? count_reg + COUNT_W'(1) : count_reg;

        cmd.has_nz     = !is_zero;
        cmd.line_end   = line_end;
        cmd.pend_count = is_zero ? count_inc : count_reg;
        cmd_wr         = accept && (!is_zero || line_end);

        count_next = count_reg;
        if (accept)
        begin
            if (!is_zero || line_end)
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/zrlm_fifo.sv]
`default_nettype none

module zrlm_fifo (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_en,
    input  wire zrlm_pkg::cmd_t  wr_data,
    input  wire                  rd_en,
    output zrlm_pkg::cmd_t       rd_data,
    output logic                 full,
    output logic                 not_empty
);
    import zrlm_pkg::*;

    localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CntW = PtrW + 1;
    localparam logic [CntW-1:0] DepthValue = CntW'(QUEUE_DEPTH);

    cmd_t            mem_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;

    always_comb
    begin
        full      = (cnt_reg == DepthValue);
        not_empty = (cnt_reg != '0);
        rd_data   = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_en ? wr_ptr_reg + PtrW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PtrW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CntW'(wr_en) - CntW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> not_empty)
        else $error("Queue read while empty.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DepthValue)
        else $error("Queue fill count out of range.");

endmodule

`default_nettype wire

[rtl/core/zrlm_back.sv]
`default_nettype none

module zrlm_back (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            head_valid,
    input  wire zrlm_pkg::cmd_t            head,
    output logic                           head_pop,
    input  wire                            pop,
    output logic                           empty,
    output logic [zrlm_pkg::LABEL_W-1:0]   run_label,
    output logic [zrlm_pkg::COUNT_W-1:0]   repeat_count,
    output logic                           line_last,
    output logic                           item_last
);
    import zrlm_pkg::*;

    localparam logic [COUNT_W-1:0] LabelMaxCount = COUNT_W'(LABEL_MAX);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               phase_reg;
    logic               phase_next;
    logic [LABEL_W-1:0] label_reg;
    logic [LABEL_W-1:0] label_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               line_last_reg;
    logic               line_last_next;
    logic               item_last_reg;
    logic               item_last_next;
    logic               load;
    logic               two_part;
    logic [LABEL_W-1:0] run_lbl;

    always_comb
    begin
        load     = head_valid && (!out_valid_reg || pop);
        two_part = head.has_nz && (head.pend_count != '0);
        run_lbl  = (head.pend_count > LabelMaxCount) ? LABEL_W'(LABEL_MAX)
                                                     : head.pend_count[LABEL_W-1:0];

        head_pop       = 1'b0;
        phase_next     = phase_reg;
        label_next     = label_reg;
        count_next     = count_reg;
        line_last_next = line_last_reg;
        item_last_next = item_last_reg;

        if (load)
        begin
            if (two_part && !phase_reg)
            begin
                label_next     = run_lbl;
                count_next     = head.pend_count;
                line_last_next = 1'b0;
                item_last_next = 1'b0;
                phase_next     = 1'b1;
            end
            else
            begin
                if (head.has_nz)
                begin
                    label_next = '0;
                    count_next = COUNT_W'(1);
                end
                else
                begin
                    label_next = run_lbl;
                    count_next = head.pend_count;
                end
                line_last_next = head.line_end;
                item_last_next = 1'b1;
                phase_next     = 1'b0;
                head_pop       = 1'b1;
            end
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        empty        = !out_valid_reg;
        run_label    = label_reg;
        repeat_count = count_reg;
        line_last    = line_last_reg;
        item_last    = item_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        label_reg     <= label_next;
        count_reg     <= count_next;
        line_last_reg <= line_last_next;
        item_last_reg <= item_last_next;
    end

    a_phase_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (head_valid && head.has_nz))
        else $error("Second result pending without a matching queued command.");

    a_first_part_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !item_last_reg) |-> (!line_last_reg && phase_reg))
        else $error("Leading run result has wrong flags or phase.");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (count_reg != '0))
        else $error("Result with a repeat count of zero.");

endmodule

`default_nettype wire
